// File: sv/vpcrp_pkg.sv
// Shared types and constants for the video processor CPU register port.
// No dependencies; imported by the sprite memory and the top level.
`default_nettype none

package vpcrp_pkg;

    // Item kinds arriving on the input channel
    typedef enum logic [1:0] {
        FUNC_CPU_READ    = 2'd0,
        FUNC_CPU_WRITE   = 2'd1,
        FUNC_VBLANK_START = 2'd2,
        FUNC_VBLANK_END  = 2'd3
    } func_t;

    // CPU register indexes
    localparam logic [2:0] REG_CONTROL   = 3'd0;
    localparam logic [2:0] REG_MASK      = 3'd1;
    localparam logic [2:0] REG_STATUS    = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
    localparam logic [2:0] REG_OAM_DATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL    = 3'd5;
    localparam logic [2:0] REG_ADDRESS   = 3'd6;
    localparam logic [2:0] REG_DATA      = 3'd7;

    // Palette space starts here; reads at or above bypass the read buffer
    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    // VRAM address increments (control bit 2 picks the row step)
    localparam logic [15:0] STEP_ROW     = 16'd32;
    localparam logic [15:0] STEP_COLUMN  = 16'd1;

    // Write port into sprite memory
    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } spr_wr_t;

endpackage

`default_nettype wire

// File: sv/vpcrp_sprite_ram.sv
// Sprite attribute memory: one write port, one registered read port.
// Per-entry valid bits make every unwritten entry read as zero after reset.
// Depends on vpcrp_pkg.
`default_nettype none

module vpcrp_sprite_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire vpcrp_pkg::spr_wr_t wr,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [7:0]            rd_data
);
    import vpcrp_pkg::*;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

`default_nettype wire

// File: sv/video_processor_cpu_register_port.sv
// Top level of the video processor CPU register port.
// Depends on vpcrp_pkg and vpcrp_sprite_ram.
`default_nettype none

// CPU register port of a tile video processor. Every input transfer is one
// CPU read, one CPU write (register index 0..7), a vblank-start event or a
// vblank-end event, and it yields exactly one output transfer carrying the
// read byte, the NMI pulse, the VRAM write strobe/data and the renderer-facing
// register copies (control, mask, t, fine x, v). An item is decoded and all
// architectural state is updated in the cycle it is accepted; its result is
// loaded into the output register by the clock edge that updates that state.
// Throughput is one item per clock: in_ready stays high while the output
// register is empty or being drained, so a full pipe keeps streaming as long
// as out_ready is high. The sprite memory read port is addressed with the
// next OAM address, so the byte for the current address is always waiting in
// its read register when an OAM data read arrives. Sprite memory comes out of
// reset reading zero everywhere (per-entry valid bits), with no clearing pass.
module video_processor_cpu_register_port_core #(
    parameter int SPRITE_MEM_DEPTH = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input channel
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire vpcrp_pkg::func_t func,
    input  wire logic [2:0]       cpu_address,
    input  wire logic [7:0]       write_data,
    input  wire logic [7:0]       vram_read_data,
    input  wire logic [7:0]       vram_shadow_data,
    input  wire logic             sprite_zero_hit,
    input  wire logic             sprite_overflow,
    input  wire logic             vblank_race,
    // output channel
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            read_data,
    output logic                  nmi_request,
    output logic                  vram_write,
    output logic [15:0]           vram_address,
    output logic [7:0]            vram_write_data,
    output logic [7:0]            control_byte,
    output logic [7:0]            mask_byte,
    output logic [14:0]           temp_address,
    output logic [2:0]            fine_x_scroll
);
    import vpcrp_pkg::*;

    localparam int SPR_AW = $clog2(SPRITE_MEM_DEPTH);

    // Architectural state
    logic [7:0]  control_reg,     control_next;
    logic [7:0]  mask_reg,        mask_next;
    logic [15:0] v_reg,           v_next;
    logic [14:0] t_reg,           t_next;
    logic [2:0]  fine_x_reg,      fine_x_next;
    logic        toggle_reg,      toggle_next;
    logic [7:0]  rbuf_reg,        rbuf_next;
    logic [7:0]  oam_addr_reg,    oam_addr_next;
    logic        nmi_en_reg,      nmi_en_next;
    logic        vblank_reg,      vblank_next;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  rd_reg,  rd_next;
    logic        nmi_reg, nmi_next;
    logic        vw_reg,  vw_next;
    logic [7:0]  vwd_reg, vwd_next;

    logic        accept;
    logic [15:0] v_step;
    logic [7:0]  spr_rd_data;
    spr_wr_t     spr_wr;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    // control bit 2: step by a row of 32 tiles instead of one
    assign v_step   = control_reg[2] ? STEP_ROW : STEP_COLUMN;

    // Item decode and next-state logic
    always_comb
    begin
        control_next  = control_reg;
        mask_next     = mask_reg;
        v_next        = v_reg;
        t_next        = t_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        rbuf_next     = rbuf_reg;
        oam_addr_next = oam_addr_reg;
        nmi_en_next   = nmi_en_reg;
        vblank_next   = vblank_reg;
        rd_next       = 8'd0;
        nmi_next      = 1'b0;
        vw_next       = 1'b0;
        vwd_next      = 8'd0;
        spr_wr.en     = 1'b0;
        spr_wr.data   = write_data;

        if (accept)
        begin
            case (func)
                FUNC_CPU_READ:
                begin
                    case (cpu_address)
                        REG_STATUS:
                        begin
                            // flag reads as 0 on the race dot but is still cleared
                            rd_next     = {vblank_reg && !vblank_race, sprite_zero_hit,
                                           sprite_overflow, 5'd0};
                            vblank_next = 1'b0;
                            toggle_next = 1'b0;
                        end
                        REG_OAM_DATA:
                        begin
                            rd_next = spr_rd_data;
                        end
                        REG_DATA:
                        begin
                            if (v_reg >= PALETTE_BASE)
                            begin
                                // palette: direct, buffer gets the shadowed nametable byte
                                rd_next   = vram_read_data;
                                rbuf_next = vram_shadow_data;
                            end
                            else
                            begin
                                rd_next   = rbuf_reg;
                                rbuf_next = vram_read_data;
                            end
                            v_next = v_reg + v_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_CPU_WRITE:
                begin
                    case (cpu_address)
                        REG_CONTROL:
                        begin
                            if (write_data[7])
                            begin
                                nmi_next    = !nmi_en_reg && vblank_reg;
                                nmi_en_next = 1'b1;
                            end
                            else
                            begin
                                nmi_en_next = 1'b0;
                            end
                            t_next       = {t_reg[14:12], write_data[1:0], t_reg[9:0]};
                            control_next = write_data;
                        end
                        REG_MASK:
                        begin
                            mask_next = write_data;
                        end
                        REG_OAM_ADDR:
                        begin
                            oam_addr_next = write_data;
                        end
                        REG_OAM_DATA:
                        begin
                            spr_wr.en     = 1'b1;
                            oam_addr_next = oam_addr_reg + 8'd1;
                        end
                        REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                fine_x_next = write_data[2:0];
                                t_next      = {t_reg[14:5], write_data[7:3]};
                            end
                            else
                            begin
                                t_next = {write_data[2:0], t_reg[11:10], write_data[7:3],
                                          t_reg[4:0]};
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_ADDRESS:
                        begin
                            if (!toggle_reg)
                            begin
                                // high byte: only six bits, bit 14 cleared
                                t_next = {1'b0, write_data[5:0], t_reg[7:0]};
                            end
                            else
                            begin
                                t_next = {t_reg[14:8], write_data};
                                v_next = {1'b0, t_reg[14:8], write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_DATA:
                        begin
                            vw_next  = 1'b1;
                            vwd_next = write_data;
                            v_next   = v_reg + v_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_VBLANK_START:
                begin
                    vblank_next = 1'b1;
                    nmi_next    = nmi_en_reg;
                end
                FUNC_VBLANK_END:
                begin
                    vblank_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sprite memory: write at the current OAM address, prefetch at the next one
    vpcrp_sprite_ram #(
        .DEPTH (SPRITE_MEM_DEPTH),
        .AW    (SPR_AW)
    ) u_sprite_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_addr (oam_addr_reg[SPR_AW-1:0]),
        .wr      (spr_wr),
        .rd_addr (oam_addr_next[SPR_AW-1:0]),
        .rd_data (spr_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= 8'd0;
            mask_reg      <= 8'd0;
            v_reg         <= 16'd0;
            t_reg         <= 15'd0;
            fine_x_reg    <= 3'd0;
            toggle_reg    <= 1'b0;
            rbuf_reg      <= 8'd0;
            oam_addr_reg  <= 8'd0;
            nmi_en_reg    <= 1'b0;
            vblank_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            control_reg  <= control_next;
            mask_reg     <= mask_next;
            v_reg        <= v_next;
            t_reg        <= t_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            rbuf_reg     <= rbuf_next;
            oam_addr_reg <= oam_addr_next;
            nmi_en_reg   <= nmi_en_next;
            vblank_reg   <= vblank_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; register copies follow state so they always match v, t, ...
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= rd_next;
            nmi_reg <= nmi_next;
            vw_reg  <= vw_next;
            vwd_reg <= vwd_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = rd_reg;
    assign nmi_request     = nmi_reg;
    assign vram_write      = vw_reg;
    assign vram_write_data = vwd_reg;
    // state only moves on accept, so these hold steady while a result waits
    assign vram_address    = v_reg;
    assign control_byte    = control_reg;
    assign mask_byte       = mask_reg;
    assign temp_address    = t_reg;
    assign fine_x_scroll   = fine_x_reg;

endmodule

`default_nettype wire

// File: sv/vpcrp_checker.sv
// Port-level checker for the video processor CPU register port, and its bind.
// Depends on the top level's port list.
`default_nettype none

module vpcrp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [7:0]       read_data,
    input wire logic             nmi_request,
    input wire logic             vram_write,
    input wire logic [7:0]       vram_write_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(nmi_request) && $stable(vram_write))
        else $error("stalled result changed");

    // every accepted transfer shows up as a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a VRAM write carries no read byte and no NMI
    a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vram_write |-> read_data == 8'd0 && !nmi_request)
        else $error("vram write mixed with read or nmi");

    // write data is zero unless strobed
    a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vram_write |-> vram_write_data == 8'd0)
        else $error("write data without strobe");

endmodule

bind video_processor_cpu_register_port_core vpcrp_checker u_vpcrp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .nmi_request     (nmi_request),
    .vram_write      (vram_write),
    .vram_write_data (vram_write_data)
);

`default_nettype wire

// File: tb/sv/vpcrp_regport_check_pkg.sv
// Scoreboard for the video processor CPU register port: per-transfer
// prediction of the result bus and in-order checking. Depends on vpcrp_pkg.
package vpcrp_regport_check_pkg;

    import vpcrp_pkg::*;

    // One accepted input transfer
    typedef struct packed {
        func_t      func;
        logic [2:0] cpu_address;
        logic [7:0] write_data;
        logic [7:0] vram_read_data;
        logic [7:0] vram_shadow_data;
        logic       sprite_zero_hit;
        logic       sprite_overflow;
        logic       vblank_race;
    } cpu_access_t;

    // One output transfer
    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_request;
        logic        vram_write;
        logic [15:0] vram_address;
        logic [7:0]  vram_write_data;
        logic [7:0]  control_byte;
        logic [7:0]  mask_byte;
        logic [14:0] temp_address;
        logic [2:0]  fine_x_scroll;
    } port_result_t;

    class regport_scoreboard;

        // Register file copy
        logic [7:0]  ctrl;
        logic [7:0]  mask;
        logic [15:0] v;
        logic [14:0] t;
        logic [2:0]  fine_x;
        logic        toggle;
        logic [7:0]  read_buf;
        logic [7:0]  oam_addr;
        logic [7:0]  oam [256];
        logic        nmi_en;
        logic        vblank;

        port_result_t pending_bus_results[$];

        int mismatches;
        int results_checked;
        int n_reads;
        int n_palette_reads;
        int n_writes;
        int n_events;
        int n_nmi;

        function new();
            ctrl = '0;
            mask = '0;
            v = '0;
            t = '0;
            fine_x = '0;
            toggle = 1'b0;
            read_buf = '0;
            oam_addr = '0;
            foreach (oam[i])
                oam[i] = '0;
            nmi_en = 1'b0;
            vblank = 1'b0;
            mismatches = 0;
            results_checked = 0;
            n_reads = 0;
            n_palette_reads = 0;
            n_writes = 0;
            n_events = 0;
            n_nmi = 0;
        endfunction

        function int pending();
            return pending_bus_results.size();
        endfunction

        // Work out the result bus for one accepted access and queue it
        function void note_access(cpu_access_t a);
            port_result_t r;
            logic [15:0]  step;
            r = '0;
            step = ctrl[2] ? STEP_ROW : STEP_COLUMN;
            case (a.func)
                FUNC_CPU_READ: begin
                    n_reads++;
                    case (a.cpu_address)
                        REG_STATUS: begin
                            r.read_data = {vblank & ~a.vblank_race, a.sprite_zero_hit,
                                           a.sprite_overflow, 5'b0};
                            vblank = 1'b0;
                            toggle = 1'b0;
                        end
                        REG_OAM_DATA: r.read_data = oam[oam_addr];
                        REG_DATA: begin
                            if (v >= PALETTE_BASE)
                            begin
                                r.read_data = a.vram_read_data;
                                read_buf = a.vram_shadow_data;
                                n_palette_reads++;
                            end
                            else
                            begin
                                r.read_data = read_buf;
                                read_buf = a.vram_read_data;
                            end
                            v = v + step;
                        end
                        default: ;
                    endcase
                end
                FUNC_CPU_WRITE: begin
                    n_writes++;
                    case (a.cpu_address)
                        REG_CONTROL: begin
                            if (a.write_data[7])
                            begin
                                if (!nmi_en && vblank)
                                    r.nmi_request = 1'b1;
                                nmi_en = 1'b1;
                            end
                            else
                                nmi_en = 1'b0;
                            t[11:10] = a.write_data[1:0];
                            ctrl = a.write_data;
                        end
                        REG_MASK: mask = a.write_data;
                        REG_OAM_ADDR: oam_addr = a.write_data;
                        REG_OAM_DATA: begin
                            oam[oam_addr] = a.write_data;
                            oam_addr = oam_addr + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (!toggle)
                            begin
                                fine_x = a.write_data[2:0];
                                t[4:0] = a.write_data[7:3];
                            end
                            else
                            begin
                                t[14:12] = a.write_data[2:0];
                                t[9:5] = a.write_data[7:3];
                            end
                            toggle = ~toggle;
                        end
                        REG_ADDRESS: begin
                            if (!toggle)
                            begin
                                t[14] = 1'b0;
                                t[13:8] = a.write_data[5:0];
                            end
                            else
                            begin
                                t[7:0] = a.write_data;
                                v = {1'b0, t};
                            end
                            toggle = ~toggle;
                        end
                        REG_DATA: begin
                            r.vram_write = 1'b1;
                            r.vram_write_data = a.write_data;
                            v = v + step;
                        end
                        default: ;
                    endcase
                end
                FUNC_VBLANK_START: begin
                    n_events++;
                    vblank = 1'b1;
                    if (nmi_en)
                        r.nmi_request = 1'b1;
                end
                default: begin
                    n_events++;
                    vblank = 1'b0;
                end
            endcase
            if (r.nmi_request)
                n_nmi++;
            r.vram_address = v;
            r.control_byte = ctrl;
            r.mask_byte = mask;
            r.temp_address = t;
            r.fine_x_scroll = fine_x;
            pending_bus_results.push_back(r);
        endfunction

        function bit field_differs(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                mismatches++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Compare one output transfer against the oldest prediction
        function void check_bus_result(port_result_t got);
            port_result_t want;
            bit           bad;
            if (pending_bus_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual 0x%0h", $time, got);
                mismatches++;
                return;
            end
            want = pending_bus_results.pop_front();
            results_checked++;
            bad = 1'b0;
            bad |= field_differs("read_data", 16'(want.read_data), 16'(got.read_data));
            bad |= field_differs("nmi_request", 16'(want.nmi_request),
                                 16'(got.nmi_request));
            bad |= field_differs("vram_write", 16'(want.vram_write), 16'(got.vram_write));
            bad |= field_differs("vram_address", want.vram_address, got.vram_address);
            bad |= field_differs("vram_write_data", 16'(want.vram_write_data),
                                 16'(got.vram_write_data));
            bad |= field_differs("control_byte", 16'(want.control_byte),
                                 16'(got.control_byte));
            bad |= field_differs("mask_byte", 16'(want.mask_byte), 16'(got.mask_byte));
            bad |= field_differs("temp_address", 16'(want.temp_address),
                                 16'(got.temp_address));
            bad |= field_differs("fine_x_scroll", 16'(want.fine_x_scroll),
                                 16'(got.fine_x_scroll));
            if (bad)
                $display("%0t:   in result %0d", $time, results_checked);
        endfunction

    endclass

endpackage

// File: tb/sv/video_processor_cpu_register_port_core_test.sv
// Testbench top for video_processor_cpu_register_port_core: directed and random
// CPU/vblank traffic with random idling. Depends on vpcrp_pkg and
// vpcrp_regport_check_pkg.
module video_processor_cpu_register_port_core_test;

    import vpcrp_pkg::*;
    import vpcrp_regport_check_pkg::*;

    // A cycle with no transfer on either side is rare: the longest legal
    // silence is a sender gap plus a receiver stall plus the pass through the
    // output register. This bound is many times that.
    localparam int IDLE_LIMIT    = 1000;
    // The wrap sweep takes most of the item budget; the random part fills it up
    localparam int RANDOM_ITEMS  = 100;
    // The tail of the random part runs with no idling on either side
    localparam int CALM_TAIL     = 40;
    // Data accesses at row step from 0x3FE0, enough to carry v past 0xFFFF
    localparam int WRAP_SWEEP    = 1540;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    func_t       func = FUNC_CPU_READ;
    logic [2:0]  cpu_address = '0;
    logic [7:0]  write_data = '0;
    logic [7:0]  vram_read_data = '0;
    logic [7:0]  vram_shadow_data = '0;
    logic        sprite_zero_hit = 1'b0;
    logic        sprite_overflow = 1'b0;
    logic        vblank_race = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [7:0]  read_data;
    logic        nmi_request;
    logic        vram_write;
    logic [15:0] vram_address;
    logic [7:0]  vram_write_data;
    logic [7:0]  control_byte;
    logic [7:0]  mask_byte;
    logic [14:0] temp_address;
    logic [2:0]  fine_x_scroll;

    // Set for the tail of the run: both sides stop idling
    bit          calm = 1'b0;
    // Set per random burst: sender runs back to back for that burst
    bit          sender_quiet = 1'b0;
    int          items_sent = 0;
    int unsigned idle_cycles = 0;

    regport_scoreboard port_check = new();

    cpu_access_t  seen_access;
    port_result_t seen_result;

    video_processor_cpu_register_port_core #(
        .SPRITE_MEM_DEPTH(256)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .cpu_address      (cpu_address),
        .write_data       (write_data),
        .vram_read_data   (vram_read_data),
        .vram_shadow_data (vram_shadow_data),
        .sprite_zero_hit  (sprite_zero_hit),
        .sprite_overflow  (sprite_overflow),
        .vblank_race      (vblank_race),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .nmi_request      (nmi_request),
        .vram_write       (vram_write),
        .vram_address     (vram_address),
        .vram_write_data  (vram_write_data),
        .control_byte     (control_byte),
        .mask_byte        (mask_byte),
        .temp_address     (temp_address),
        .fine_x_scroll    (fine_x_scroll)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog. Everything is sampled at the rising edge, so it
    // sees pre-edge values of both the driven inputs and the registered
    // outputs. The input is noted before the output is checked, so even a
    // same-edge result would pair correctly.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen_access.func = func;
                seen_access.cpu_address = cpu_address;
                seen_access.write_data = write_data;
                seen_access.vram_read_data = vram_read_data;
                seen_access.vram_shadow_data = vram_shadow_data;
                seen_access.sprite_zero_hit = sprite_zero_hit;
                seen_access.sprite_overflow = sprite_overflow;
                seen_access.vblank_race = vblank_race;
                port_check.note_access(seen_access);
            end
            if (out_valid && out_ready)
            begin
                seen_result.read_data = read_data;
                seen_result.nmi_request = nmi_request;
                seen_result.vram_write = vram_write;
                seen_result.vram_address = vram_address;
                seen_result.vram_write_data = vram_write_data;
                seen_result.control_byte = control_byte;
                seen_result.mask_byte = mask_byte;
                seen_result.temp_address = temp_address;
                seen_result.fine_x_scroll = fine_x_scroll;
                port_check.check_bus_result(seen_result);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, port_check.pending());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: outside the calm tail, out_ready drops in random bursts, with stretches of
    // steady acceptance in between. One nonblocking write per edge at most.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int pick;
        forever
        begin
            @(posedge clk);
            pick = $urandom_range(0, 15);
            if (!calm && pick == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (pick == 1)
                repeat ($urandom_range(20, 100)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    function automatic cpu_access_t make_access(func_t f, logic [2:0] r, logic [7:0] wd,
                                                logic race);
        cpu_access_t a;
        a.func = f;
        a.cpu_address = r;
        a.write_data = wd;
        a.vram_read_data = 8'($urandom_range(0, 255));
        a.vram_shadow_data = 8'($urandom_range(0, 255));
        a.sprite_zero_hit = 1'($urandom_range(0, 1));
        a.sprite_overflow = 1'($urandom_range(0, 1));
        a.vblank_race = race;
        return a;
    endfunction

    // Called at the edge where the previous transfer went through (or right
    // after reset). Either drops valid for a gap or presents the next item at
    // once, never both at one edge.
    task automatic send_access(cpu_access_t a);
        if (!calm && !sender_quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= a.func;
        cpu_address <= a.cpu_address;
        write_data <= a.write_data;
        vram_read_data <= a.vram_read_data;
        vram_shadow_data <= a.vram_shadow_data;
        sprite_zero_hit <= a.sprite_zero_hit;
        sprite_overflow <= a.sprite_overflow;
        vblank_race <= a.vblank_race;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    function automatic logic rand_race();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic send_write(logic [2:0] r, logic [7:0] wd);
        send_access(make_access(FUNC_CPU_WRITE, r, wd, rand_race()));
    endtask

    task automatic send_read(logic [2:0] r);
        send_access(make_access(FUNC_CPU_READ, r, 8'($urandom_range(0, 255)), rand_race()));
    endtask

    task automatic send_event(func_t f);
        send_access(make_access(f, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                rand_race()));
    endtask

    task automatic send_data_access();
        if ($urandom_range(0, 1))
            send_write(REG_DATA, 8'($urandom_range(0, 255)));
        else
            send_read(REG_DATA);
    endtask

    // Short directed pass: NMI rules, status race, every register, OAM and
    // palette corners.
    task automatic directed_pass();
        send_access(make_access(FUNC_CPU_READ, REG_STATUS, 8'h00, 1'b0));  // flag clear
        send_write(REG_CONTROL, 8'h80);              // enable, no flag: no NMI
        send_event(FUNC_VBLANK_START);               // NMI on vblank start
        send_access(make_access(FUNC_CPU_READ, REG_STATUS, 8'hFF, 1'b1));  // race dot
        send_event(FUNC_VBLANK_START);
        send_write(REG_CONTROL, 8'h00);
        send_write(REG_CONTROL, 8'hFF);              // enable while flag set: NMI
        send_event(FUNC_VBLANK_END);
        send_write(REG_MASK, 8'hFF);
        send_write(REG_STATUS, 8'hFF);               // ignored
        send_write(REG_OAM_ADDR, 8'hFF);
        send_write(REG_OAM_DATA, 8'hA5);
        send_write(REG_OAM_DATA, 8'h5A);             // written at 0 after the wrap
        send_write(REG_OAM_ADDR, 8'hFF);
        send_read(REG_OAM_DATA);
        send_write(REG_SCROLL, 8'hFF);
        send_write(REG_SCROLL, 8'hFF);
        send_write(REG_ADDRESS, 8'hFF);
        send_write(REG_ADDRESS, 8'h00);              // v = 0x3F00, palette
        send_read(REG_DATA);
        send_write(REG_DATA, 8'hFF);
        send_read(REG_CONTROL);                      // unused read registers
        send_read(REG_MASK);
        send_read(REG_OAM_ADDR);
        send_read(REG_SCROLL);
        send_read(REG_ADDRESS);
    endtask

    // Row-step data accesses from 0x3FE0 until v wraps past 0xFFFF
    task automatic wrap_sweep();
        send_read(REG_STATUS);
        send_write(REG_CONTROL, 8'h04);
        send_write(REG_ADDRESS, 8'h3F);
        send_write(REG_ADDRESS, 8'hE0);
        repeat (WRAP_SWEEP) send_data_access();
    endtask

    // One random burst: mostly well-formed register sequences with random
    // content, some half-finished latch writes and plain noise.
    task automatic random_burst();
        int         kind;
        logic [7:0] hi;
        kind = $urandom_range(0, 99);
        sender_quiet = ($urandom_range(0, 3) == 0);
        if (kind < 20)
        begin
            hi = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                hi[5:0] = 6'h3F;                     // land in palette space
            send_write(REG_ADDRESS, hi);
            send_write(REG_ADDRESS, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 6)) send_data_access();
        end
        else if (kind < 30)
        begin
            send_write(REG_SCROLL, 8'($urandom_range(0, 255)));
            send_write(REG_SCROLL, 8'($urandom_range(0, 255)));
        end
        else if (kind < 42)
        begin
            send_write(REG_OAM_ADDR, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 1))
                    send_write(REG_OAM_DATA, 8'($urandom_range(0, 255)));
                else
                    send_read(REG_OAM_DATA);
            end
        end
        else if (kind < 52)
            send_write(REG_CONTROL, 8'($urandom_range(0, 255)));
        else if (kind < 62)
        begin
            send_event(FUNC_VBLANK_START);
            repeat ($urandom_range(0, 2))
            begin
                if ($urandom_range(0, 1))
                    send_read(REG_STATUS);
                else
                    send_write(REG_CONTROL, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1))
                send_event(FUNC_VBLANK_END);
        end
        else if (kind < 70)
            send_read(REG_STATUS);
        else if (kind < 76)
            send_write(REG_MASK, 8'($urandom_range(0, 255)));
        else if (kind < 84)
        begin
            // first half of a latch pair, then a status read resets the toggle
            if ($urandom_range(0, 1))
                send_write(REG_SCROLL, 8'($urandom_range(0, 255)));
            else
                send_write(REG_ADDRESS, 8'($urandom_range(0, 255)));
            send_read(REG_STATUS);
        end
        else
            send_access(make_access(func_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                    8'($urandom_range(0, 255)), rand_race()));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_flow
        int random_start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_pass();
        wrap_sweep();

        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS)
        begin
            if (items_sent >= random_start + RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            random_burst();
        end
        in_valid <= 1'b0;

        // Drain; the watchdog covers a result that never shows up. The first
        // edge lets the monitor note the last transfer before the count is read.
        do
            @(posedge clk);
        while (port_check.pending() != 0);
        repeat (4) @(posedge clk);

        $display("%0d transfers checked: %0d reads (%0d from palette), %0d writes,",
                 port_check.results_checked, port_check.n_reads,
                 port_check.n_palette_reads, port_check.n_writes);
        $display("%0d vblank events, %0d NMI pulses, %0d field mismatches",
                 port_check.n_events, port_check.n_nmi, port_check.mismatches);
        if (port_check.mismatches == 0 && port_check.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/vpcrp_pkg.sv
sv/vpcrp_sprite_ram.sv
sv/video_processor_cpu_register_port.sv
sv/vpcrp_checker.sv
tb/sv/vpcrp_regport_check_pkg.sv
tb/sv/video_processor_cpu_register_port_core_test.sv
